/* rtl/order_statistic_multiset_assert.svh */
// Assertion macros for the order statistic multiset.
// Used by the top level; expects signals clk and rst in the including scope.
`ifndef ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define OSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define OSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/osm_pkg.sv */
// Shared constants and controller/datapath interface types for the
// order statistic multiset. No dependencies.
package osm_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int KEY_WIDTH_DEF = 31;
  localparam int RANK_W        = 8;
  localparam int STATUS_W      = 2;

  // Request types
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request beat
    logic init_ins;    // pos <= count
    logic init_rem;    // pos <= 0, found <= 0
    logic set_full;    // status <= full
    logic rd_prev;     // read entry pos-1
    logic rd_pos;      // read entry pos
    logic rd_rank;     // read entry rank
    logic shift_down;  // write read data at pos, pos--
    logic place_key;   // write key at pos, count++
    logic rem_step;    // close gap or mark match, pos++
    logic rem_end;     // count-- on match, else status absent
    logic kth_miss;    // rank out of range
    logic kth_take;    // capture read data as result key
    logic emit;        // load result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_remove;
    logic full;
    logic pos_zero;
    logic pos_end;
    logic rd_gt;
    logic rank_ok;
    logic out_free;
  } sts_t;

endpackage

/* rtl/osm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/osm_ctrl.sv */
// Sequencer for insert, remove and rank read of the multiset.
// Depends on osm_pkg for the command and status types.
module osm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  osm_pkg::sts_t sts,
  output osm_pkg::cmd_t cmd
);
  import osm_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_INS_CHK = 4'd2;
  localparam logic [3:0] S_INS_CMP = 4'd3;
  localparam logic [3:0] S_REM_CHK = 4'd4;
  localparam logic [3:0] S_REM_CMP = 4'd5;
  localparam logic [3:0] S_KREAD   = 4'd6;
  localparam logic [3:0] S_KWAIT   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_stall = (state != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op_remove) begin
          cmd.init_rem = 1'b1;
          state_next   = S_REM_CHK;
        end else if (sts.full) begin
          cmd.set_full = 1'b1;
          state_next   = S_KREAD;
        end else begin
          cmd.init_ins = 1'b1;
          state_next   = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts.pos_zero) begin
          cmd.place_key = 1'b1;
          state_next    = S_KREAD;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.rd_gt) begin
          cmd.shift_down = 1'b1;
          state_next     = S_INS_CHK;
        end else begin
          cmd.place_key = 1'b1;
          state_next    = S_KREAD;
        end
      end
      S_REM_CHK: begin
        if (sts.pos_end) begin
          cmd.rem_end = 1'b1;
          state_next  = S_KREAD;
        end else begin
          cmd.rd_pos = 1'b1;
          state_next = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        cmd.rem_step = 1'b1;
        state_next   = S_REM_CHK;
      end
      S_KREAD: begin
        if (sts.rank_ok) begin
          cmd.rd_rank = 1'b1;
          state_next  = S_KWAIT;
        end else begin
          cmd.kth_miss = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_KWAIT: begin
        cmd.kth_take = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/osm_datapath.sv */
// Datapath of the multiset: sorted key RAM, count, scan pointer and
// result register. Depends on osm_pkg and osm_ram.
module osm_datapath #(
  parameter int CAPACITY  = osm_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = osm_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  osm_pkg::cmd_t                    cmd,
  output osm_pkg::sts_t                    sts,
  input  logic                             req_type,
  input  logic [KEY_WIDTH-1:0]             key_value,
  input  logic [osm_pkg::RANK_W-1:0]       rank,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [KEY_WIDTH-1:0]             kth_key,
  output logic [$clog2(CAPACITY+1)-1:0]    entry_total,
  output logic [osm_pkg::STATUS_W-1:0]     status
);
  import osm_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int RK_W   = (ADDR_W > RANK_W) ? ADDR_W : RANK_W;
  localparam int CMP_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // Request and working registers
  logic                 op;
  logic [KEY_WIDTH-1:0] key;
  logic [RANK_W-1:0]    rank_q;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     pos;
  logic                 found;
  logic [STATUS_W-1:0]  st;
  logic [KEY_WIDTH-1:0] kth;

  logic [CNT_W-1:0]     pos_dec;
  logic [RK_W-1:0]      rank_ext;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  assign pos_dec  = pos - CNT_W'(1);
  assign rank_ext = RK_W'(rank_q);

  // Steer RAM ports from the current command
  always_comb begin
    ram_we    = cmd.shift_down | cmd.place_key | (cmd.rem_step & found);
    ram_waddr = cmd.rem_step ? pos_dec[ADDR_W-1:0] : pos[ADDR_W-1:0];
    ram_wdata = cmd.place_key ? key : ram_rdata;
    ram_re    = cmd.rd_prev | cmd.rd_pos | cmd.rd_rank;
    if (cmd.rd_prev) begin
      ram_raddr = pos_dec[ADDR_W-1:0];
    end else if (cmd.rd_pos) begin
      ram_raddr = pos[ADDR_W-1:0];
    end else begin
      ram_raddr = rank_ext[ADDR_W-1:0];
    end
  end

  osm_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Report conditions to the controller
  always_comb begin
    sts.op_remove = (op == OP_REMOVE);
    sts.full      = (count >= CNT_W'(CAPACITY));
    sts.pos_zero  = (pos == '0);
    sts.pos_end   = (pos == count);
    sts.rd_gt     = (ram_rdata > key);
    sts.rank_ok   = (CMP_W'(rank_q) < CMP_W'(count));
    sts.out_free  = !res_valid || !res_stall;
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= req_type;
      key    <= key_value;
      rank_q <= rank;
      st     <= ST_OK;
    end
    if (cmd.init_ins) begin
      pos <= count;
    end
    if (cmd.init_rem) begin
      pos   <= '0;
      found <= 1'b0;
    end
    if (cmd.set_full) begin
      st <= ST_FULL;
    end
    if (cmd.shift_down) begin
      pos <= pos_dec;
    end
    // Mark the first match, then close the gap behind it
    if (cmd.rem_step) begin
      if (!found && ram_rdata == key) begin
        found <= 1'b1;
      end
      pos <= pos + CNT_W'(1);
    end
    if (cmd.rem_end && !found) begin
      st <= ST_ABSENT;
    end
    if (cmd.kth_miss) begin
      kth <= '0;
      if (st == ST_OK) begin
        st <= ST_RANGE;
      end
    end
    if (cmd.kth_take) begin
      kth <= ram_rdata;
    end
  end

  // Key count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.place_key) begin
      count <= count + CNT_W'(1);
    end else if (cmd.rem_end && found) begin
      count <= count - CNT_W'(1);
    end
  end

  // Result register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kth_key     <= kth;
      entry_total <= count;
      status      <= st;
    end
  end

endmodule

/* rtl/order_statistic_multiset.sv */
// Sorted multiset of up to CAPACITY keys with a rank query after every
// insert or remove. One request is in work at a time, and the input stalls
// until its result has gone into the output register. An insert moves the
// larger keys up one by one, starting at the top, and then places its key.
// A remove scans every held key, marks the first match and closes the gap
// behind it. A dropped insert skips the scan, and a rank out of range skips
// the read of the key RAM. Each scan step is a read followed by a compare
// and a write, since the read of the key RAM is registered. The next beat
// can be taken in the same cycle in which the result appears. While the
// receiver still holds an earlier result, the sequencer waits before it
// loads the new one. No clearing pass is needed after reset, because only
// entries below the count are read.
`include "order_statistic_multiset_assert.svh"

module order_statistic_multiset #(
  parameter int CAPACITY  = osm_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = osm_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             req_type,
  input  logic [KEY_WIDTH-1:0]             key_value,
  input  logic [osm_pkg::RANK_W-1:0]       rank,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [KEY_WIDTH-1:0]             kth_key,
  output logic [$clog2(CAPACITY+1)-1:0]    entry_total,
  output logic [osm_pkg::STATUS_W-1:0]     status
);
  import osm_pkg::*;

  localparam int TOTAL_W = $clog2(CAPACITY + 1);

  cmd_t cmd;
  sts_t sts;

  osm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  osm_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .key_value   (key_value),
    .rank        (rank),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kth_key     (kth_key),
    .entry_total (entry_total),
    .status      (status)
  );

  // A dropped insert only happens with the store at capacity
  `OSM_ASSERT_NOW(a_full_total, res_valid && status == ST_FULL, entry_total == TOTAL_W'(CAPACITY), "full status with store not at capacity")
  // Out-of-range results carry a zero key
  `OSM_ASSERT_NOW(a_range_zero, res_valid && status == ST_RANGE, kth_key == '0, "rank miss with nonzero key")
  // An accepted beat occupies the sequencer in the next cycle
  `OSM_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "sequencer idle right after accept")

endmodule
